>>> design/wnm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wnm_pkg;

  localparam int CharW   = 16;
  localparam int WordW   = 64;
  localparam int LenW    = 5;
  localparam int CfgIdxW = 3;
  localparam int CharsPerWord = WordW / CharW;

  localparam logic [CharW-1:0] WildOne = 16'h003F;
  localparam logic [CharW-1:0] WildAny = 16'h002A;

  typedef enum logic [CfgIdxW-1:0] {
    RegWord0  = 3'd0,
    RegWord1  = 3'd1,
    RegWord2  = 3'd2,
    RegWord3  = 3'd3,
    RegLength = 3'd4
  } cfg_reg_e;

  // Signals handed from one pattern position to the next.
  typedef struct packed {
    logic adv;    // position advanced on the current character
    logic clos;   // reached through a star that matches nothing
    logic start;  // part of the start set of the pattern
  } link_t;

  // Case folding limited to ASCII lower-case letters.
  function automatic logic [CharW-1:0] fold(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if ((c >= 16'h0061) && (c <= 16'h007A)) begin
      r = c - 16'h0020;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/wnm_intf.sv
`timescale 1ns / 1ps
`default_nettype none

interface wnm_name_if;
  logic                      valid;
  logic                      ready;
  logic [wnm_pkg::CharW-1:0] name_char;
  logic                      end_of_name;

  modport source (output valid, output name_char, output end_of_name, input ready);
  modport sink (input valid, input name_char, input end_of_name, output ready);
endinterface

interface wnm_match_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink (input valid, input matched, output ready);
endinterface

`default_nettype wire

>>> design/wnm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module wnm_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      char_we_i,
  input  wire logic [wnm_pkg::CharW-1:0] char_i,
  input  wire logic                      en_i,
  input  wire logic                      restart_i,
  input  wire logic                      load_i,
  input  wire logic [wnm_pkg::CharW-1:0] name_char_i,
  input  wire wnm_pkg::link_t            link_i,
  output wnm_pkg::link_t                 link_o,
  output logic                           pos_o
);

  logic [wnm_pkg::CharW-1:0] char_q;
  logic                      act_q;
  logic                      act_d;
  logic                      cur;
  logic                      is_star;
  logic                      hit;
  logic                      nxt;

  always_comb begin
    cur     = restart_i ? link_i.start : act_q;
    is_star = en_i && (char_q == wnm_pkg::WildAny);
    hit     = (char_q == wnm_pkg::WildOne) ||
              (wnm_pkg::fold(char_q) == wnm_pkg::fold(name_char_i));
    nxt     = (cur && is_star) || link_i.adv || link_i.clos;
    link_o.adv   = cur && en_i && !is_star && hit;
    link_o.clos  = nxt && is_star;
    link_o.start = link_i.start && is_star;
    pos_o        = nxt;
    act_d        = load_i ? nxt : act_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= '0;
      act_q  <= 1'b0;
    end else begin
      if (char_we_i) begin
        char_q <= char_i;
      end
      act_q <= act_d;
    end
  end

endmodule

`default_nettype wire

>>> design/wildcard_name_matcher.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Role    Payload                  Transaction
// name_in    sink    name_char, end_of_name   one name character
// match_out  source  matched                  one result per name
// cfg        write   cfg_idx_i, cfg_data_i    one register write
//
// One name character is taken every cycle; the position set is updated through
// the row of pattern cells in that same cycle, star closure rippling from cell to cell.
// The result for the last character waits in an output
// register backed by one skid entry, so input stalls only when both are full.
// Reset leaves an empty pattern and the start set; a write to any of the five registers also returns to the start set.

module wildcard_name_matcher #(
  parameter int PATTERN_CHARS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  wnm_name_if.sink                         name_in,
  wnm_match_if.source                      match_out,
  input  wire logic                        cfg_we_i,
  input  wire logic [wnm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [wnm_pkg::WordW-1:0]   cfg_data_i
);

  localparam int PosW = $clog2(PATTERN_CHARS + 1);

  wnm_pkg::link_t           link [PATTERN_CHARS+1];
  logic [PATTERN_CHARS:0]   pos;
  logic [wnm_pkg::LenW-1:0] len_q;
  logic [wnm_pkg::LenW-1:0] len_d;
  logic [PosW-1:0]          len_eff;
  logic                     restart_q;
  logic                     restart_d;
  logic                     cfg_hit;
  logic                     step;
  logic                     load;
  logic                     push;
  logic                     push_val;
  logic                     pop;
  logic                     out_vld_q, out_vld_d;
  logic                     out_q, out_d;
  logic                     skid_vld_q, skid_vld_d;
  logic                     skid_q, skid_d;

  assign cfg_hit = cfg_we_i && (cfg_idx_i <= wnm_pkg::RegLength);
  assign step    = name_in.valid && name_in.ready;
  assign load    = step && !name_in.end_of_name;
  assign len_eff = (len_q > wnm_pkg::LenW'(PATTERN_CHARS)) ?
                   PosW'(PATTERN_CHARS) : PosW'(len_q);

  assign link[0] = '{adv: 1'b0, clos: 1'b0, start: 1'b1};

  for (genvar i = 0; i < PATTERN_CHARS; i++) begin : g_cell
    wnm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .char_we_i   (cfg_we_i && (cfg_idx_i == wnm_pkg::CfgIdxW'(i / wnm_pkg::CharsPerWord))),
      .char_i      (cfg_data_i[(i % wnm_pkg::CharsPerWord)*wnm_pkg::CharW +: wnm_pkg::CharW]),
      .en_i        (PosW'(i) < len_eff),
      .restart_i   (restart_q),
      .load_i      (load),
      .name_char_i (name_in.name_char),
      .link_i      (link[i]),
      .link_o      (link[i+1]),
      .pos_o       (pos[i])
    );
  end

  assign pos[PATTERN_CHARS] = link[PATTERN_CHARS].adv || link[PATTERN_CHARS].clos;

  always_comb begin
    len_d     = len_q;
    restart_d = restart_q;
    if (cfg_we_i && (cfg_idx_i == wnm_pkg::RegLength)) begin
      len_d = cfg_data_i[wnm_pkg::LenW-1:0];
    end
    if (cfg_hit) begin
      restart_d = 1'b1;
    end else if (step) begin
      restart_d = name_in.end_of_name;
    end
  end

  assign push     = step && name_in.end_of_name;
  assign push_val = (len_eff == '0) ? 1'b1 : pos[len_eff];
  assign pop      = out_vld_q && match_out.ready;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = push;
        out_d     = push_val;
      end
    end else if (push) begin
      skid_vld_d = 1'b1;
      skid_d     = push_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      restart_q  <= 1'b1;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      len_q      <= len_d;
      restart_q  <= restart_d;
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign name_in.ready   = !skid_vld_q;
  assign match_out.valid = out_vld_q;
  assign match_out.matched = out_q;

endmodule

`default_nettype wire

>>> design/wnm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wnm_props (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        in_eon,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        out_matched,
  input wire logic                        cfg_we,
  input wire logic [wnm_pkg::CfgIdxW-1:0] cfg_idx,
  input wire logic [wnm_pkg::LenW-1:0]    cfg_len
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A pending result is held until the sink takes it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // With nothing queued, only a final character can create a result.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid && !(in_acc && in_eon) |=> !out_valid)
    else $error("result without a final character");

  // A final character taken with an empty output shows its result next cycle.
  a_result_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid && in_acc && in_eon |=> out_valid)
    else $error("result missing after final character");

  // An empty pattern matches a one-character name.
  a_empty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we && (cfg_idx == wnm_pkg::RegLength) && (cfg_len == '0))
    ##1 (in_acc && in_eon && !out_valid && !cfg_we) |=> out_matched)
    else $error("empty pattern did not match");

endmodule

bind wildcard_name_matcher wnm_props u_wnm_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (name_in.valid),
  .in_ready    (name_in.ready),
  .in_eon      (name_in.end_of_name),
  .out_valid   (match_out.valid),
  .out_ready   (match_out.ready),
  .out_matched (match_out.matched),
  .cfg_we      (cfg_we_i),
  .cfg_idx     (cfg_idx_i),
  .cfg_len     (cfg_data_i[wnm_pkg::LenW-1:0])
);

`default_nettype wire

>>> verif/wnm_checker.sv
`timescale 1ns / 1ps

module wnm_checker #(
  parameter int PATTERN_CHARS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  wnm_name_if                         name_mon,
  wnm_match_if                        match_mon,
  input  logic                        cfg_we_i,
  input  logic [wnm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [wnm_pkg::WordW-1:0]   cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o
);

  logic [wnm_pkg::WordW-1:0] pat_words [4];
  logic [wnm_pkg::LenW-1:0]  pat_len_q;
  logic [16:0]               live_pos;
  bit                        match_expect_q [$];
  int                        fail_count;
  int                        checked;

  function automatic int used_len();
    return (pat_len_q > PATTERN_CHARS) ? PATTERN_CHARS : int'(pat_len_q);
  endfunction

  function automatic logic [wnm_pkg::CharW-1:0] pat_at(input int i);
    return pat_words[i / wnm_pkg::CharsPerWord]
                    [(i % wnm_pkg::CharsPerWord) * wnm_pkg::CharW +: wnm_pkg::CharW];
  endfunction

  function automatic logic [wnm_pkg::CharW-1:0] to_upper(input logic [wnm_pkg::CharW-1:0] c);
    return (c >= 16'h0061 && c <= 16'h007A) ? c - 16'h0020 : c;
  endfunction

  // A star may match nothing, so every live star also makes the next position live.
  function automatic logic [16:0] spread_stars(input logic [16:0] s, input int n);
    for (int i = 0; i < n; i++) begin
      if (s[i] && pat_at(i) == wnm_pkg::WildAny) begin
        s[i + 1] = 1'b1;
      end
    end
    return s;
  endfunction

  function automatic logic [16:0] advance(input logic [16:0] cur,
                                          input logic [wnm_pkg::CharW-1:0] c,
                                          input int n);
    logic [16:0]               nxt;
    logic [wnm_pkg::CharW-1:0] p;
    nxt = '0;
    for (int i = 0; i < n; i++) begin
      if (cur[i]) begin
        p = pat_at(i);
        if (p == wnm_pkg::WildAny) begin
          nxt[i] = 1'b1;
        end else if (p == wnm_pkg::WildOne || to_upper(p) == to_upper(c)) begin
          nxt[i + 1] = 1'b1;
        end
      end
    end
    return spread_stars(nxt, n);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit known_reg;
    bit want;
    int n;
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        pat_words[k] = '0;
      end
      pat_len_q = '0;
      live_pos = 17'd1;
      match_expect_q.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (match_mon.valid && match_mon.ready) begin
        checked++;
        if (match_expect_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transaction, expected none, got matched=%0b",
                   $time, match_mon.matched);
        end else begin
          want = match_expect_q.pop_front();
          if (match_mon.matched !== want) begin
            fail_count++;
            $display("%0t: matched mismatch, expected %0b, got %0b",
                     $time, want, match_mon.matched);
          end
        end
      end

      if (cfg_we_i) begin
        known_reg = 1'b1;
        case (wnm_pkg::cfg_reg_e'(cfg_idx_i))
          wnm_pkg::RegWord0, wnm_pkg::RegWord1, wnm_pkg::RegWord2, wnm_pkg::RegWord3:
            pat_words[cfg_idx_i[1:0]] = cfg_data_i;
          wnm_pkg::RegLength: pat_len_q = cfg_data_i[wnm_pkg::LenW-1:0];
          default: known_reg = 1'b0;
        endcase
        if (known_reg) begin
          live_pos = spread_stars(17'd1, used_len());
        end
      end

      if (name_mon.valid && name_mon.ready) begin
        n = used_len();
        live_pos = advance(live_pos, name_mon.name_char, n);
        if (name_mon.end_of_name) begin
          match_expect_q.insert(match_expect_q.size(), (n == 0) ? 1'b1 : live_pos[n]);
          live_pos = spread_stars(17'd1, n);
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o <= match_expect_q.size();
    checked_o <= checked;
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CharTarget = 775;
  localparam int CycleLimit = 300000;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  wnm_pkg::cfg_reg_e         cfg_idx;
  logic [wnm_pkg::WordW-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;

  wnm_name_if  name_bus ();
  wnm_match_if match_bus ();

  wildcard_name_matcher #(
    .PATTERN_CHARS(16)
  ) i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .name_in   (name_bus),
    .match_out (match_bus),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  wnm_checker #(
    .PATTERN_CHARS(16)
  ) i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .name_mon    (name_bus),
    .match_mon   (match_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [wnm_pkg::CharW-1:0] pat [16];
  logic [wnm_pkg::LenW-1:0]  pat_len;
  logic [wnm_pkg::CharW-1:0] name_q [$];
  bit                        idle_on = 1'b1;
  bit                        stall_req = 1'b0;
  int                        stall_len = 0;
  int                        chars_sent = 0;
  int                        names_sent = 0;
  int                        settings_used = 0;
  int                        cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    match_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        match_bus.ready = 1'b0;
        stall_req = 1'b0;
        repeat (stall_len) @(negedge clk);
      end
      match_bus.ready = rst_n && !(idle_on && $urandom_range(99) < 6);
    end
  end

  function automatic logic [wnm_pkg::CharW-1:0] letter();
    return ($urandom_range(1) ? 16'h0041 : 16'h0061) + 16'($urandom_range(2));
  endfunction

  function automatic logic [wnm_pkg::CharW-1:0] flip_case(input logic [wnm_pkg::CharW-1:0] c);
    if (c >= 16'h0061 && c <= 16'h007A) return c - 16'h0020;
    if (c >= 16'h0041 && c <= 16'h005A) return c + 16'h0020;
    return c;
  endfunction

  function automatic logic [wnm_pkg::CharW-1:0] rand_char();
    case ($urandom_range(9))
      0, 1, 2, 8, 9: return letter();
      3: return $urandom_range(1) ? wnm_pkg::WildAny : wnm_pkg::WildOne;
      4: begin
        case ($urandom_range(5))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'h0060;
          3: return 16'h007B;
          4: return 16'h0040;
          default: return 16'h005B;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [wnm_pkg::CharW-1:0] rand_pat_char();
    case ($urandom_range(9))
      0, 1, 2: return wnm_pkg::WildAny;
      3, 4: return wnm_pkg::WildOne;
      9: return rand_char();
      default: return letter();
    endcase
  endfunction

  // Mostly names built to fit the pattern, some of them damaged, a few pure noise.
  function automatic void build_name();
    int n;
    int mode;
    int pos;
    logic [wnm_pkg::CharW-1:0] c;
    n = (pat_len > 16) ? 16 : int'(pat_len);
    mode = $urandom_range(9);
    name_q.delete();
    if (mode == 9) begin
      repeat ($urandom_range(1, 6)) name_q.insert(name_q.size(), rand_char());
    end else begin
      for (int i = 0; i < n; i++) begin
        if (pat[i] == wnm_pkg::WildAny) begin
          repeat ($urandom_range(0, 2)) name_q.insert(name_q.size(), rand_char());
        end else if (pat[i] == wnm_pkg::WildOne) begin
          name_q.insert(name_q.size(), rand_char());
        end else begin
          c = pat[i];
          if ($urandom_range(1)) c = flip_case(c);
          name_q.insert(name_q.size(), c);
        end
      end
      if (mode == 7 && name_q.size() > 0) begin
        pos = $urandom_range(name_q.size() - 1);
        name_q[pos] = rand_char();
      end else if (mode == 8) begin
        if ($urandom_range(1) && name_q.size() > 1) name_q.pop_back();
        else name_q.insert(name_q.size(), rand_char());
      end
    end
    if (name_q.size() == 0) name_q.insert(name_q.size(), rand_char());
  endfunction

  task automatic push_char(input logic [wnm_pkg::CharW-1:0] c, input logic last);
    @(negedge clk);
    if (idle_on && $urandom_range(99) < 6) begin
      name_bus.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    name_bus.valid = 1'b1;
    name_bus.name_char = c;
    name_bus.end_of_name = last;
    do @(posedge clk); while (!name_bus.ready);
    chars_sent++;
  endtask

  task automatic send_name();
    for (int i = 0; i < name_q.size(); i++) begin
      push_char(name_q[i], i == name_q.size() - 1);
    end
    names_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    name_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_pattern();
    wnm_pkg::cfg_reg_e         word_regs [4];
    logic [wnm_pkg::WordW-1:0] w;
    word_regs = '{wnm_pkg::RegWord0, wnm_pkg::RegWord1, wnm_pkg::RegWord2, wnm_pkg::RegWord3};
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < wnm_pkg::CharsPerWord; j++) begin
        w[j * wnm_pkg::CharW +: wnm_pkg::CharW] = pat[k * wnm_pkg::CharsPerWord + j];
      end
      @(negedge clk);
      cfg_we = 1'b1;
      cfg_idx = word_regs[k];
      cfg_data = w;
    end
    @(negedge clk);
    cfg_idx = wnm_pkg::RegLength;
    cfg_data = wnm_pkg::WordW'(pat_len);
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  task automatic use_pattern(input logic [wnm_pkg::CharW-1:0] chars [$],
                             input logic [wnm_pkg::LenW-1:0] n,
                             input logic [wnm_pkg::CharW-1:0] fill);
    for (int k = 0; k < 16; k++) begin
      pat[k] = (k < chars.size()) ? chars[k] : fill;
    end
    pat_len = n;
    wait_drained();
    load_pattern();
  endtask

  task automatic send_chars(input logic [wnm_pkg::CharW-1:0] chars [$]);
    name_q = chars;
    send_name();
  endtask

  task automatic pick_setting(input int ph);
    for (int k = 0; k < 16; k++) begin
      pat[k] = rand_pat_char();
    end
    case (ph % 8)
      0: pat_len = 5'd0;
      1: pat_len = 5'd16;
      2: pat_len = 5'd31;
      3: pat_len = wnm_pkg::LenW'($urandom_range(1, 4));
      4: begin
        for (int k = 0; k < 16; k++) pat[k] = wnm_pkg::WildAny;
        pat_len = wnm_pkg::LenW'($urandom_range(1, 16));
      end
      5: begin
        for (int k = 0; k < 16; k++) pat[k] = wnm_pkg::WildOne;
        pat_len = wnm_pkg::LenW'($urandom_range(1, 6));
      end
      6: begin
        for (int k = 0; k < 16; k++) pat[k] = 16'($urandom);
        pat_len = wnm_pkg::LenW'($urandom_range(1, 3));
      end
      default: pat_len = wnm_pkg::LenW'($urandom_range(0, 31));
    endcase
  endtask

  initial begin
    int budget;
    int first;
    name_bus.valid = 1'b0;
    name_bus.name_char = '0;
    name_bus.end_of_name = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = wnm_pkg::RegWord0;
    cfg_data = '0;
    rst_n = 1'b0;
    pat_len = '0;
    for (int k = 0; k < 16; k++) pat[k] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The empty pattern left by reset takes any name.
    send_chars('{16'hFFFF, 16'h0000});

    use_pattern('{16'h0061, wnm_pkg::WildOne, 16'h0043, wnm_pkg::WildAny}, 5'd4, 16'h0000);
    send_chars('{16'h0061, 16'h0058, 16'h0063});
    send_chars('{16'h0062, wnm_pkg::WildOne, 16'h0063});
    send_chars('{16'h0041, wnm_pkg::WildAny, 16'h0063, 16'h0051});

    // An oversized length is clipped; the zero character is matched literally.
    use_pattern('{16'h0000}, 5'd31, wnm_pkg::WildAny);
    send_chars('{16'h0000});
    send_chars('{16'h0078});

    use_pattern('{wnm_pkg::WildOne}, 5'd1, 16'hFFFF);
    send_chars('{16'hFFFF});
    send_chars('{16'h007A, 16'h007A});

    // A register write abandons the partly sent name.
    push_char(16'h0061, 1'b0);
    push_char(16'h0062, 1'b0);
    use_pattern('{wnm_pkg::WildAny}, 5'd1, 16'h0000);
    send_chars('{16'h0071});

    // Folding covers letters only, not their neighbors.
    use_pattern('{16'h005A, 16'h0060}, 5'd2, 16'h0000);
    send_chars('{16'h007A, 16'h0060});
    send_chars('{16'h007A, 16'h0040});

    for (int ph = 0; chars_sent < CharTarget; ph++) begin
      pick_setting(ph);
      wait_drained();
      load_pattern();
      idle_on = (ph % 8 != 3);
      if (ph == 2) begin
        build_name();
        send_name();
        stall_len = 150;
        stall_req = 1'b1;
        repeat (15) begin
          push_char(rand_char(), 1'b1);
          names_sent++;
        end
      end
      budget = $urandom_range(30, 90);
      first = chars_sent;
      while (chars_sent - first < budget && chars_sent < CharTarget) begin
        build_name();
        send_name();
        if ($urandom_range(24) == 0) wait_drained();
      end
    end
    idle_on = 1'b1;

    wait_drained();
    repeat (6) @(negedge clk);
    $display("Run covered %0d names (%0d characters) over %0d pattern settings.",
             names_sent, chars_sent, settings_used);
    $display("%0d results compared, %0d failures.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/wnm_pkg.sv
design/wnm_intf.sv
design/wnm_cell.sv
design/wildcard_name_matcher.sv
design/wnm_checker.sv
verif/wnm_checker.sv
verif/tb_top.sv
